// ===== rtl/mhpf_pkg.sv =====
`timescale 1ns / 1ps
// mhpf_pkg: shared constants and controller/datapath types for the
// masked histogram peak finder. No dependencies.
package mhpf_pkg;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_WINDOW_LOW   = 2'd0;
    localparam logic [1:0] REG_WINDOW_WIDTH = 2'd1;
    localparam logic [1:0] REG_SELECT_LABEL = 2'd2;

    localparam logic signed [15:0] RST_WINDOW_LOW   = -16'sd1000;
    localparam logic [8:0]         RST_WINDOW_WIDTH = 9'd200;
    localparam logic [7:0]         RST_SELECT_LABEL = 8'd1;

    typedef struct packed {
        logic voxel_rd;     // latch voxel, read its bin
        logic inc_wr;       // write back incremented bin
        logic sweep_step;   // read bin at sweep counter, write zero, advance
        logic sweep_score;  // feed swept bin into peak compare
        logic out_load;     // load peak into output register, clear best
    } t_cmd;

    typedef struct packed {
        logic sweep_end;    // sweep counter at last bin
        logic last;         // latched voxel was the last of its volume
        logic out_full;     // output register holds an item
    } t_sts;

endpackage

// ===== rtl/mhpf_vox_if.sv =====
`timescale 1ns / 1ps
// mhpf_vox_if: voxel input channel (valid/ready plus voxel payload).
// No dependencies.
interface mhpf_vox_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] voxel_value;
    logic [7:0]         voxel_label;
    logic               last_voxel;

    modport source (output valid, voxel_value, voxel_label, last_voxel, input ready);
    modport sink   (input valid, voxel_value, voxel_label, last_voxel, output ready);
endinterface

// ===== rtl/mhpf_peak_if.sv =====
`timescale 1ns / 1ps
// mhpf_peak_if: peak result channel (valid/ready plus peak level).
// No dependencies.
interface mhpf_peak_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] peak_level;

    modport source (output valid, peak_level, input ready);
    modport sink   (input valid, peak_level, output ready);
endinterface

// ===== rtl/mhpf_cfg.sv =====
`timescale 1ns / 1ps
// mhpf_cfg: APB register file for window_low, window_width, select_label.
// Depends on mhpf_pkg.
module mhpf_cfg
    import mhpf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [APB_AW-1:0]   paddr,
    input  logic [APB_DW-1:0]   pwdata,
    output logic [APB_DW-1:0]   prdata,
    output logic                pready,
    output logic signed [15:0]  o_window_low,
    output logic [8:0]          o_window_width,
    output logic [7:0]          o_select_label
);

    logic signed [15:0] r_window_low;
    logic [8:0]         r_window_width;
    logic [7:0]         r_select_label;
    logic               wr_en;
    logic [1:0]         reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_low   <= RST_WINDOW_LOW;
            r_window_width <= RST_WINDOW_WIDTH;
            r_select_label <= RST_SELECT_LABEL;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WINDOW_LOW:   r_window_low   <= $signed(pwdata[15:0]);
                REG_WINDOW_WIDTH: r_window_width <= pwdata[8:0];
                REG_SELECT_LABEL: r_select_label <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WINDOW_LOW:   prdata = {{(APB_DW-16){r_window_low[15]}}, r_window_low};
            REG_WINDOW_WIDTH: prdata = {{(APB_DW-9){1'b0}}, r_window_width};
            REG_SELECT_LABEL: prdata = {{(APB_DW-8){1'b0}}, r_select_label};
            default:          prdata = '0;
        endcase
    end

    assign o_window_low   = r_window_low;
    assign o_window_width = r_window_width;
    assign o_select_label = r_select_label;

endmodule

// ===== rtl/mhpf_ctrl.sv =====
`timescale 1ns / 1ps
// mhpf_ctrl: sequencer for clear pass, voxel update, peak scan and emit.
// Depends on mhpf_pkg.
module mhpf_ctrl
    import mhpf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_INC   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.sweep_step = 1'b1;
                if (i_sts.sweep_end) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.voxel_rd = 1'b1;
                    n_state        = S_INC;
                end
            end
            S_INC: begin
                o_cmd.inc_wr = 1'b1;
                n_state      = i_sts.last ? S_SCAN : S_IDLE;
            end
            S_SCAN: begin
                o_cmd.sweep_step  = 1'b1;
                o_cmd.sweep_score = 1'b1;
                if (i_sts.sweep_end) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_sts.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/mhpf_dp.sv =====
`timescale 1ns / 1ps
// mhpf_dp: bin memory, voxel window test, saturating update, peak compare
// and output register. Depends on mhpf_pkg.
module mhpf_dp
    import mhpf_pkg::*;
#(
    parameter int NUM_BINS    = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [15:0] i_window_low,
    input  logic [8:0]         i_window_width,
    input  logic [7:0]         i_select_label,
    input  logic signed [15:0] i_voxel_value,
    input  logic [7:0]         i_voxel_label,
    input  logic               i_last_voxel,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [15:0] o_peak_level
);

    localparam int IDX_W = $clog2(NUM_BINS);

    logic [COUNT_WIDTH-1:0] r_mem [NUM_BINS];
    logic [COUNT_WIDTH-1:0] r_rdata;

    logic [IDX_W-1:0]       r_addr;
    logic                   r_hit;
    logic                   r_last;
    logic [IDX_W-1:0]       r_cnt;
    logic [IDX_W-1:0]       r_score_idx;
    logic                   r_score_vld;
    logic [COUNT_WIDTH-1:0] r_best_cnt;
    logic [IDX_W-1:0]       r_best_idx;
    logic                   r_out_vld;
    logic signed [15:0]     r_out_lvl;

    logic [16:0]            eff_width;
    logic signed [16:0]     diff;
    logic                   hit;
    logic [IDX_W-1:0]       raddr;
    logic [IDX_W-1:0]       waddr;
    logic [COUNT_WIDTH-1:0] wdata;
    logic                   wen;
    logic                   sweep_end;

    assign eff_width = (17'(i_window_width) > 17'(NUM_BINS)) ? 17'(NUM_BINS)
                                                              : 17'(i_window_width);
    assign diff = $signed({i_voxel_value[15], i_voxel_value})
                - $signed({i_window_low[15], i_window_low});
    assign hit  = (i_voxel_label == i_select_label) && !diff[16]
               && (17'(unsigned'(diff)) < eff_width);

    assign sweep_end = (r_cnt == IDX_W'(NUM_BINS - 1));

    assign raddr = i_cmd.voxel_rd ? diff[IDX_W-1:0] : r_cnt;
    assign waddr = i_cmd.inc_wr ? r_addr : r_cnt;
    assign wen   = (i_cmd.inc_wr & r_hit) | i_cmd.sweep_step;
    assign wdata = !i_cmd.inc_wr ? '0
                 : (r_rdata == '1) ? r_rdata : r_rdata + COUNT_WIDTH'(1);

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[raddr];
        if (wen) begin
            r_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.voxel_rd) begin
            r_addr <= diff[IDX_W-1:0];
            r_hit  <= hit;
        end
        r_score_idx <= r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= 1'b0;
            r_cnt       <= '0;
            r_score_vld <= 1'b0;
            r_best_cnt  <= '0;
            r_best_idx  <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cmd.voxel_rd) begin
                r_last <= i_last_voxel;
            end
            if (i_cmd.sweep_step) begin
                r_cnt <= sweep_end ? '0 : r_cnt + IDX_W'(1);
            end
            r_score_vld <= i_cmd.sweep_step & i_cmd.sweep_score;
            if (i_cmd.out_load) begin
                r_best_cnt <= '0;
                r_best_idx <= '0;
            end else if (r_score_vld && (17'(r_score_idx) < eff_width)
                         && (r_rdata > r_best_cnt)) begin
                r_best_cnt <= r_rdata;
                r_best_idx <= r_score_idx;
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_lvl <= i_window_low + $signed(16'(r_best_idx));
        end
    end

    assign o_sts.sweep_end = sweep_end;
    assign o_sts.last      = r_last;
    assign o_sts.out_full  = r_out_vld;
    assign o_out_valid     = r_out_vld;
    assign o_peak_level    = r_out_lvl;

endmodule

// ===== rtl/masked_histogram_peak_finder.sv =====
`timescale 1ns / 1ps
// masked_histogram_peak_finder: top level, joins APB registers, controller
// and datapath. Depends on mhpf_pkg, mhpf_vox_if, mhpf_peak_if, mhpf_cfg,
// mhpf_ctrl, mhpf_dp.
//
// Usage: voxels arrive on i_vox (valid/ready). A voxel whose label matches
// select_label and whose value is in [window_low, window_low+w), w being
// window_width capped at NUM_BINS, bumps its bin (saturating). On a voxel
// with last_voxel set the bins are swept in order and o_peak carries
// window_low plus the index of the first strictly largest bin; the sweep
// also zeroes every bin. Each voxel is a bin read, then its write back;
// input is not ready again until then. A last voxel holds the input
// through the one-bin-per-cycle sweep, a drain and the emit, which waits
// for a free output register. Reset: after i_rst_n releases, a clearing
// pass zeroes the bins with ready low; APB writes are taken throughout.
// Stall: the result sits in an output register; the next volume streams
// in meanwhile, and its sweep result waits until the register is free.
// Registers: APB at 0x0 window_low, 0x4 window_width, 0x8 select_label.
module masked_histogram_peak_finder
    import mhpf_pkg::*;
#(
    parameter int NUM_BINS    = 256,
    parameter int COUNT_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mhpf_vox_if.sink          i_vox,
    mhpf_peak_if.source       o_peak,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic signed [15:0] window_low;
    logic [8:0]         window_width;
    logic [7:0]         select_label;
    t_cmd               cmd;
    t_sts               sts;
    logic               in_ready;
    logic               out_valid;
    logic signed [15:0] peak_level;

    mhpf_cfg u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_window_low   (window_low),
        .o_window_width (window_width),
        .o_select_label (select_label)
    );

    mhpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_vox.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mhpf_dp #(
        .NUM_BINS    (NUM_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_window_low   (window_low),
        .i_window_width (window_width),
        .i_select_label (select_label),
        .i_voxel_value  (i_vox.voxel_value),
        .i_voxel_label  (i_vox.voxel_label),
        .i_last_voxel   (i_vox.last_voxel),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_out_valid    (out_valid),
        .i_out_ready    (o_peak.ready),
        .o_peak_level   (peak_level)
    );

    assign i_vox.ready       = in_ready;
    assign o_peak.valid      = out_valid;
    assign o_peak.peak_level = peak_level;

endmodule
